/* rtl/core/sequence_reorder_buffer_assert.svh */
// Assertion macros for the reorder buffer.
`ifndef SEQUENCE_REORDER_BUFFER_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define SRB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srb_pkg.sv */
package srb_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int MAX_PAYLOAD  = 1000;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int SEQ_W   = 32;
    localparam int SEQ_U_W = 31;
    localparam int LEN_W   = 11;
    localparam int LEN_U_W = 10;
    localparam int WORD_W  = 64;

    localparam int TDATA_IN_W  = 112;
    localparam int TDATA_OUT_W = 112;

    localparam logic [SEQ_U_W-1:0] SEQ_MAX = {SEQ_U_W{1'b1}};

    // input beat classes
    localparam logic [2:0] CLS_NEG    = 3'd0;
    localparam logic [2:0] CLS_END    = 3'd1;
    localparam logic [2:0] CLS_DIRECT = 3'd2;
    localparam logic [2:0] CLS_DROP   = 3'd3;
    localparam logic [2:0] CLS_PARK   = 3'd4;
    localparam logic [2:0] CLS_STALE  = 3'd5;

    typedef struct packed {
        logic               kind;
        logic [SEQ_U_W-1:0] seq;
        logic [LEN_U_W-1:0] len;
        logic [WORD_W-1:0]  word;
        logic               done;
        logic               last;
    } result_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic emit_drop;
        logic advance;
        logic flush_last;
    } srb_cmd_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       hit;
        logic       hold_valid;
        logic       out_free;
    } srb_status_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_U_W-1:0] seq);
        return SLOT_W'(seq % WINDOW_DEPTH);
    endfunction

endpackage

/* rtl/core/sequence_reorder_buffer.sv */
// channel   dir   tdata fields (low bit up)                  tuser   tlast
// s_        in    pkt_seq[31:0] pkt_len[42:32] pkt_word[106:43]  -   -
// m_        out   out_seq[30:0] out_len[40:31] out_word[104:41]
//                 stream_done[105]                           kind    last_in_run
//
// A packet beat passes through accept, classify and slot lookup; a negative
// sequence, end marker or dropped beat passes through accept and classify only.
// Each parked packet drained after it adds a lookup in the registered slot RAM.
// Reset clears the window through per-slot valid flops at once; no sweep.
// A result waits in the output register while m_tready is low; the drain
// stalls only when a second result is ready behind it.
module sequence_reorder_buffer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srb_pkg::TDATA_IN_W-1:0]    s_tdata,  // pkt_seq, pkt_len, pkt_word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srb_pkg::TDATA_OUT_W-1:0]   m_tdata,  // out_seq, out_len, out_word,
                                                        // stream_done
    output logic                              m_tuser,  // kind
    output logic                              m_tlast
);
    import srb_pkg::*;

    srb_cmd_t    cmd;
    srb_status_t st;

    srb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    srb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`include "sequence_reorder_buffer_assert.svh"

    `SRB_ASSERT_NOW(a_idle_no_hold, aclk, aresetn, s_tready, !st.hold_valid, "held result at idle")
    `SRB_ASSERT_NOW(a_drop_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata[104:31] == 0), "bad drop notice")
    `SRB_ASSERT_NOW(a_advance_hit, aclk, aresetn, cmd.advance, st.hit, "drain without slot hit")
    `SRB_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after accept")

endmodule

/* rtl/core/srb_ctrl.sv */
module srb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srb_pkg::srb_status_t st,
    output srb_pkg::srb_cmd_t    cmd
);
    import srb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (st.cls)
                    CLS_NEG: begin
                        state_next = ST_IDLE;
                    end
                    CLS_END: begin
                        cmd.eval   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CLS_DROP: begin
                        if (st.out_free) begin
                            cmd.emit_drop = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    CLS_DIRECT, CLS_PARK, CLS_STALE: begin
                        cmd.eval   = 1'b1;
                        state_next = ST_CHECK;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CHECK: begin
                // held result goes out only once we know whether another follows
                if (st.hit) begin
                    if (!st.hold_valid || st.out_free) begin
                        cmd.advance = 1'b1;
                    end
                end else if (st.hold_valid) begin
                    if (st.out_free) begin
                        cmd.flush_last = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/srb_dp.sv */
module srb_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [srb_pkg::TDATA_IN_W-1:0]    s_tdata,
    input  srb_pkg::srb_cmd_t                 cmd,
    output srb_pkg::srb_status_t              st,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [srb_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import srb_pkg::*;

    typedef struct packed {
        logic [SEQ_U_W-1:0] seq;
        logic [LEN_U_W-1:0] len;
        logic [WORD_W-1:0]  word;
    } slot_t;

    // latched input beat
    logic [SEQ_W-1:0]  in_seq_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic [WORD_W-1:0] in_word_reg;

    logic [SEQ_U_W-1:0]      delivered_reg, delivered_next;
    logic signed [SEQ_W-1:0] highest_reg, highest_next;
    logic                    end_seen_reg, end_seen_next;
    logic [WINDOW_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    rd_valid_reg;
    result_t                 hold_reg, hold_next;
    result_t                 out_reg, out_next;
    slot_t                   rd_data_reg;

    slot_t slot_mem [WINDOW_DEPTH];

    logic [SEQ_U_W-1:0]      seq_u;
    logic signed [SEQ_W-1:0] seq_s;
    logic [LEN_U_W-1:0]      len_sat;
    logic [SEQ_W-1:0]        expect_seq;
    logic [SEQ_U_W-1:0]      gap;
    logic [SEQ_U_W-1:0]      nx;
    logic signed [SEQ_W-1:0] highest_max;
    logic [2:0]              cls;
    logic                    done_now;
    logic                    done_direct;
    logic                    done_adv;
    logic                    hit;
    logic                    out_free;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    slot_t                   wr_data;

    assign seq_u       = in_seq_reg[SEQ_U_W-1:0];
    assign seq_s       = $signed({1'b0, seq_u});
    assign len_sat     = (in_len_reg[LEN_U_W-1:0] > LEN_U_W'(MAX_PAYLOAD)) ?
                         LEN_U_W'(MAX_PAYLOAD) : in_len_reg[LEN_U_W-1:0];
    assign expect_seq  = {1'b0, delivered_reg} + 32'd1;
    assign gap         = seq_u - delivered_reg;
    assign nx          = delivered_reg + 31'd1;
    assign highest_max = (seq_s > highest_reg) ? seq_s : highest_reg;

    always_comb begin
        if (in_seq_reg[SEQ_W-1]) begin
            cls = CLS_NEG;
        end else if (in_len_reg[LEN_W-1]) begin
            cls = CLS_END;
        end else if ({1'b0, seq_u} == expect_seq) begin
            cls = CLS_DIRECT;
        end else if (seq_u > delivered_reg) begin
            cls = (gap > SEQ_U_W'(WINDOW_DEPTH)) ? CLS_DROP : CLS_PARK;
        end else begin
            cls = CLS_STALE;
        end
    end

    assign done_now    = end_seen_reg && ($signed({1'b0, delivered_reg}) >= highest_reg);
    assign done_direct = end_seen_reg && (seq_s >= highest_max);
    assign done_adv    = end_seen_reg && ($signed({1'b0, nx}) >= highest_reg);

    assign hit = rd_valid_reg && (rd_data_reg.seq == nx) && (delivered_reg != SEQ_MAX)
                 && !done_now && (cnt_reg < CNT_W'(WINDOW_DEPTH));

    assign out_free = !out_valid_reg || m_tready;

    assign st.cls        = cls;
    assign st.hit        = hit;
    assign st.hold_valid = hold_valid_reg;
    assign st.out_free   = out_free;

    // slot lookup for the next expected sequence
    assign rd_en   = (cmd.eval && (cls != CLS_END)) || cmd.advance;
    always_comb begin
        if (cmd.advance) begin
            rd_addr = slot_of(nx + 31'd1);
        end else if (cls == CLS_DIRECT) begin
            rd_addr = slot_of(seq_u + 31'd1);
        end else begin
            rd_addr = slot_of(nx);
        end
    end

    assign wr_en        = cmd.eval && (cls == CLS_PARK);
    assign wr_addr      = slot_of(seq_u);
    assign wr_data.seq  = seq_u;
    assign wr_data.len  = len_sat;
    assign wr_data.word = in_word_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_comb begin
        delivered_next  = delivered_reg;
        highest_next    = highest_reg;
        end_seen_next   = end_seen_reg;
        slot_valid_next = slot_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (cmd.eval) begin
            case (cls)
                CLS_END: begin
                    highest_next  = seq_s - 32'sd1;
                    end_seen_next = 1'b1;
                end
                CLS_DIRECT: begin
                    delivered_next  = seq_u;
                    highest_next    = highest_max;
                    hold_next.kind  = 1'b0;
                    hold_next.seq   = seq_u;
                    hold_next.len   = len_sat;
                    hold_next.word  = in_word_reg;
                    hold_next.done  = done_direct;
                    hold_next.last  = 1'b0;
                    hold_valid_next = 1'b1;
                    cnt_next        = CNT_W'(1);
                end
                CLS_PARK: begin
                    slot_valid_next[wr_addr] = 1'b1;
                    highest_next    = highest_max;
                    hold_valid_next = 1'b0;
                    cnt_next        = '0;
                end
                default: begin
                    hold_valid_next = 1'b0;
                    cnt_next        = '0;
                end
            endcase
        end

        if (cmd.emit_drop) begin
            out_next.kind  = 1'b1;
            out_next.seq   = seq_u;
            out_next.len   = '0;
            out_next.word  = '0;
            out_next.done  = done_now;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
        end

        if (cmd.advance) begin
            if (hold_valid_reg) begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            delivered_next  = nx;
            hold_next.kind  = 1'b0;
            hold_next.seq   = nx;
            hold_next.len   = rd_data_reg.len;
            hold_next.word  = rd_data_reg.word;
            hold_next.done  = done_adv;
            hold_next.last  = 1'b0;
            hold_valid_next = 1'b1;
            cnt_next        = cnt_reg + CNT_W'(1);
        end

        if (cmd.flush_last) begin
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_seq_reg  <= s_tdata[SEQ_W-1:0];
            in_len_reg  <= s_tdata[SEQ_W+LEN_W-1:SEQ_W];
            in_word_reg <= s_tdata[SEQ_W+LEN_W+WORD_W-1:SEQ_W+LEN_W];
        end
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delivered_reg  <= '0;
            highest_reg    <= '0;
            end_seen_reg   <= 1'b0;
            slot_valid_reg <= '0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end else begin
            delivered_reg  <= delivered_next;
            highest_reg    <= highest_next;
            end_seen_reg   <= end_seen_next;
            slot_valid_reg <= slot_valid_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            if (rd_en) begin
                rd_valid_reg <= slot_valid_reg[rd_addr];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.done, out_reg.word, out_reg.len, out_reg.seq};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

/* dv/sequence_reorder_buffer_tb.sv */
`timescale 1ns / 1ps

module sequence_reorder_buffer_tb;
    import srb_pkg::*;

    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         RAND_PKTS    = 180;
    localparam int         CALM_AFTER   = 140;
    localparam int         DRAIN_WAIT   = 80;
    localparam int         MAX_REPORTS  = 10;
    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_DROP    = 1'b1;
    localparam logic [10:0] LEN_EOS     = 11'h7FF;
    localparam logic [10:0] LEN_EOS_MIN = 11'h400;

    typedef struct {
        logic [31:0] seq;
        logic [10:0] len;
        logic [63:0] word;
    } pkt_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;     // pkt_seq, pkt_len, pkt_word
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;           // out_seq, out_len, out_word, stream_done
    logic                   m_tuser;           // kind
    logic                   m_tlast;

    pkt_t    pending[$];
    result_t exp_results[$];
    pkt_t    cur_pkt;
    int      s_gap       = 0;
    int      m_stall     = 0;
    bit      jitter_on   = 1'b1;
    int      err_count   = 0;
    int      cycle_cnt   = 0;

    // shadow of the reorder state
    logic [31:0] dlv_upto;
    logic [31:0] win_base;
    longint      top_seq;
    bit          eos_seen;
    logic [31:0] park_seq  [WINDOW_DEPTH];
    logic [9:0]  park_len  [WINDOW_DEPTH];
    logic [63:0] park_word [WINDOW_DEPTH];

    sequence_reorder_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic result_t make_result(logic kind, logic [31:0] seq, logic [9:0] len,
                                            logic [63:0] word);
        result_t r;
        r.kind = kind;
        r.seq  = seq[SEQ_U_W-1:0];
        r.len  = len;
        r.word = word;
        r.done = eos_seen && (longint'({32'b0, dlv_upto}) >= top_seq);
        r.last = 1'b0;
        return r;
    endfunction

    task automatic reorder_predict(input pkt_t p);
        result_t     batch[$];
        logic [9:0]  len;
        logic [31:0] nx;
        int          slot;
        bit          going;
        begin
            if (p.seq[31])
                return;
            if (p.len[10]) begin
                top_seq  = longint'({32'b0, p.seq}) - 1;
                eos_seen = 1'b1;
                return;
            end
            len = (p.len > MAX_PAYLOAD) ? 10'(MAX_PAYLOAD) : p.len[9:0];

            if (p.seq == dlv_upto + 32'd1) begin
                dlv_upto = p.seq;
                win_base = dlv_upto;
                if (longint'({32'b0, p.seq}) > top_seq)
                    top_seq = longint'({32'b0, p.seq});
                batch.push_back(make_result(KIND_DATA, p.seq, len, p.word));
            end else if (p.seq > win_base) begin
                if (p.seq - dlv_upto > WINDOW_DEPTH) begin
                    batch.push_back(make_result(KIND_DROP, p.seq, '0, '0));
                    batch[0].last = 1'b1;
                    exp_results.push_back(batch[0]);
                    return;
                end
                slot = p.seq % WINDOW_DEPTH;
                park_seq[slot]  = p.seq;
                park_len[slot]  = len;
                park_word[slot] = p.word;
                if (longint'({32'b0, p.seq}) > top_seq)
                    top_seq = longint'({32'b0, p.seq});
            end

            // walk parked successors; the end marker can hold this back
            going = 1'b1;
            while (going && batch.size() < WINDOW_DEPTH && dlv_upto < 32'h7FFF_FFFF) begin
                nx   = dlv_upto + 32'd1;
                slot = nx % WINDOW_DEPTH;
                if (park_seq[slot] != nx)
                    going = 1'b0;
                else if (eos_seen && longint'({32'b0, dlv_upto}) >= top_seq)
                    going = 1'b0;
                else begin
                    dlv_upto = nx;
                    win_base = dlv_upto;
                    batch.push_back(make_result(KIND_DATA, nx, park_len[slot],
                                                park_word[slot]));
                end
            end

            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[i])
                exp_results.push_back(batch[i]);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                reorder_predict(cur_pkt);
            if (!s_tvalid || s_tready) begin
                if (s_gap != 0) begin
                    s_gap = s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_pkt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, cur_pkt.word, cur_pkt.len, cur_pkt.seq};
                    if (jitter_on && $urandom_range(0, 5) == 0)
                        s_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.seq  = m_tdata[30:0];
                got.len  = m_tdata[40:31];
                got.word = m_tdata[104:41];
                got.done = m_tdata[105];
                got.last = m_tlast;
                if (exp_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected beat: kind=%0b seq=%0d len=%0d word=%h done=%0b last=%0b",
                                 got.kind, got.seq, got.len, got.word, got.done, got.last);
                end else begin
                    want = exp_results.pop_front();
                    if (got.kind !== want.kind || got.seq !== want.seq ||
                        got.len !== want.len || got.word !== want.word ||
                        got.done !== want.done || got.last !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("mismatch exp: kind=%0b seq=%0d len=%0d word=%h done=%0b last=%0b",
                                     want.kind, want.seq, want.len, want.word, want.done,
                                     want.last);
                            $display("         got: kind=%0b seq=%0d len=%0d word=%h done=%0b last=%0b",
                                     got.kind, got.seq, got.len, got.word, got.done, got.last);
                        end
                    end
                end
            end
            if (m_stall != 0) begin
                m_stall = m_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (jitter_on && $urandom_range(0, 4) == 0)
                    m_stall = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic pkt_t mk_pkt(logic [31:0] seq, logic [10:0] len, logic [63:0] word);
        pkt_t p;
        p.seq  = seq;
        p.len  = len;
        p.word = word;
        return p;
    endfunction

    function automatic logic [10:0] rand_len();
        if ($urandom_range(0, 9) == 0)
            return 11'($urandom_range(MAX_PAYLOAD + 1, 1023));
        return 11'($urandom_range(0, MAX_PAYLOAD));
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_input_idle();
        do @(negedge aclk); while (pending.size() != 0 || s_tvalid);
    endtask

    initial begin
        pkt_t        blk[$];
        pkt_t        tmp;
        logic [31:0] base;
        logic [31:0] far;
        int          k;
        int          j;
        int          pos;
        int          sent;
        int          blk_no;

        dlv_upto = '0;
        win_base = '0;
        top_seq  = 0;
        eos_seen = 1'b0;
        foreach (park_seq[i]) begin
            park_seq[i]  = '0;
            park_len[i]  = '0;
            park_word[i] = '0;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: in-order, saturation, ignored, drops, parking, overwrite, end marker
        pending.push_back(mk_pkt(32'd1, 11'd0, 64'd0));
        pending.push_back(mk_pkt(32'd2, 11'd1000, '1));
        pending.push_back(mk_pkt(32'd3, 11'd1023, rand_word()));
        pending.push_back(mk_pkt(32'h8000_0000, 11'd5, rand_word()));
        pending.push_back(mk_pkt(32'hFFFF_FFFF, 11'd7, rand_word()));
        pending.push_back(mk_pkt(32'd2, 11'd5, rand_word()));
        pending.push_back(mk_pkt(32'd0, 11'd5, rand_word()));
        pending.push_back(mk_pkt(32'd68, 11'd9, rand_word()));
        pending.push_back(mk_pkt(32'h7FFF_FFFF, 11'd9, rand_word()));
        pending.push_back(mk_pkt(32'd67, 11'd11, rand_word()));
        pending.push_back(mk_pkt(32'd5, 11'd20, rand_word()));
        pending.push_back(mk_pkt(32'd5, 11'd21, rand_word()));
        pending.push_back(mk_pkt(32'd4, 11'd22, rand_word()));
        pending.push_back(mk_pkt(32'd8, 11'd1, rand_word()));
        pending.push_back(mk_pkt(32'd7, 11'd2, rand_word()));
        pending.push_back(mk_pkt(32'd6, 11'd3, rand_word()));
        pending.push_back(mk_pkt(32'd10, LEN_EOS, rand_word()));
        pending.push_back(mk_pkt(32'd9, 11'd4, rand_word()));
        pending.push_back(mk_pkt(32'd11, 11'd5, rand_word()));
        pending.push_back(mk_pkt(32'd10, 11'd6, rand_word()));
        pending.push_back(mk_pkt(32'd12, LEN_EOS_MIN, rand_word()));
        pending.push_back(mk_pkt(32'h8000_0005, LEN_EOS, rand_word()));
        // end marker below a parked packet holds the drain
        pending.push_back(mk_pkt(32'd13, 11'd7, rand_word()));
        pending.push_back(mk_pkt(32'd13, LEN_EOS, rand_word()));
        pending.push_back(mk_pkt(32'd12, 11'd8, rand_word()));

        sent   = 0;
        blk_no = 0;
        while (sent < RAND_PKTS) begin
            wait_input_idle();
            if (sent >= CALM_AFTER)
                jitter_on = 1'b0;
            base = dlv_upto;
            blk.delete();

            if (blk_no == 3) begin
                // fill the whole window, then release it with the missing head
                for (j = 2; j <= WINDOW_DEPTH; j++)
                    blk.push_back(mk_pkt(base + j, rand_len(), rand_word()));
                for (j = blk.size() - 1; j > 0; j--) begin
                    pos = $urandom_range(0, j);
                    tmp = blk[j];
                    blk[j] = blk[pos];
                    blk[pos] = tmp;
                end
                blk.push_back(mk_pkt(base + 1, rand_len(), rand_word()));
            end else begin
                k = $urandom_range(1, 10);
                for (j = 1; j <= k; j++)
                    blk.push_back(mk_pkt(base + j, rand_len(), rand_word()));
                for (j = blk.size() - 1; j > 0; j--) begin
                    pos = $urandom_range(0, j);
                    tmp = blk[j];
                    blk[j] = blk[pos];
                    blk[pos] = tmp;
                end
                // broken run: one packet goes missing
                if (k > 1 && $urandom_range(0, 7) == 0)
                    blk.delete($urandom_range(0, blk.size() - 1));
                if ($urandom_range(0, 5) == 0)
                    blk.insert($urandom_range(0, blk.size()), blk[$urandom_range(0, blk.size() - 1)]);
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        far = {1'b0, 31'($urandom)};
                    else
                        far = base + k + 1;
                    blk.insert($urandom_range(0, blk.size()),
                               mk_pkt(far, {1'b1, 10'($urandom)}, rand_word()));
                end
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        far = base + WINDOW_DEPTH + 1 + $urandom_range(0, 1000);
                    else
                        far = {1'b0, 31'($urandom)};
                    blk.insert($urandom_range(0, blk.size()), mk_pkt(far, rand_len(), rand_word()));
                end
                // noise the block ignores
                if ($urandom_range(0, 3) == 0)
                    blk.insert($urandom_range(0, blk.size()),
                               mk_pkt({1'b1, 31'($urandom)}, 11'($urandom), rand_word()));
                if ($urandom_range(0, 4) == 0)
                    blk.insert($urandom_range(0, blk.size()),
                               mk_pkt(32'($urandom_range(0, base)), rand_len(), rand_word()));
            end

            foreach (blk[i]) begin
                pending.push_back(blk[i]);
                if (!blk[i].seq[31] && blk[i].seq > base)
                    sent++;
            end
            blk_no++;
        end

        wait_input_idle();
        while (exp_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (err_count == 0 && exp_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
